// ----- design/saf_pkg.sv -----
package saf_pkg;

  localparam int TDATA_W = 176;
  localparam int CORDIC_STEPS = 24;
  localparam int STEPS_PER_CYCLE = 4;
  localparam int CORDIC_CYCLES = CORDIC_STEPS / STEPS_PER_CYCLE;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [28:0] DELAY_MUL = 29'sd3845732;
  localparam logic [3:0] MAC_LAST = 4'd15;
  localparam logic [7:0] CFG_NUM_STATIONS = 8'd0;
  localparam logic [7:0] CFG_REF_FREQ = 8'd1;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [6:0]         station_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        dir_azimuth;
    logic [15:0]        dir_elevation;
    logic [15:0]        ref_azimuth;
    logic [15:0]        ref_elevation;
    logic [27:0]        frequency_hz;
  } item_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_q15;
    logic signed [15:0] sin_q15;
  } cordic_res_t;

  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_DIR_START,
    ENG_DIR_WAIT,
    ENG_KVEC,
    ENG_READ,
    ENG_MAC,
    ENG_ROT_WAIT,
    ENG_DIV_SETUP,
    ENG_DIV,
    ENG_OUT
  } eng_state_t;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      return 16'sd32767;
    end else if (r < -34'sd32767) begin
      return -16'sd32767;
    end
    return r[15:0];
  endfunction

endpackage

// ----- design/saf_front.sv -----
module saf_front
  import saf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               pop,
  output logic               item_valid,
  output item_t              item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      incoming;
  logic       push;

  always_comb begin
    incoming.op            = op_t'(s_axis_tuser);
    incoming.station_index = s_axis_tdata[6:0];
    incoming.pos_x         = s_axis_tdata[30:7];
    incoming.pos_y         = s_axis_tdata[54:31];
    incoming.pos_z         = s_axis_tdata[78:55];
    incoming.dir_azimuth   = s_axis_tdata[94:79];
    incoming.dir_elevation = s_axis_tdata[110:95];
    incoming.ref_azimuth   = s_axis_tdata[126:111];
    incoming.ref_elevation = s_axis_tdata[142:127];
    incoming.frequency_hz  = s_axis_tdata[170:143];
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (count != 2'd0);
  assign item          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_full_step: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> count == 2'd2) else $error("full queue lost a word");

endmodule

// ----- design/saf_cordic.sv -----
module saf_cordic
  import saf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] angle,
  output cordic_res_t res
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [1:0]         quad;
  logic [2:0]         cnt;
  logic               busy;
  logic               done;
  logic signed [33:0] x_next;
  logic signed [33:0] y_next;
  logic signed [33:0] z_next;
  logic [1:0]         q_start;
  logic [31:0]        r_start;
  logic signed [15:0] cx;
  logic signed [15:0] cy;

  assign q_start = angle[31:30] + {1'b0, angle[29]};
  assign r_start = angle - {q_start, 30'b0};

  always_comb begin
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [4:0]         i;
    x_next = x;
    y_next = y;
    z_next = z;
    for (int j = 0; j < STEPS_PER_CYCLE; j++) begin
      i  = 5'(cnt * STEPS_PER_CYCLE + j);
      dx = y_next >>> i;
      dy = x_next >>> i;
      if (z_next >= 0) begin
        x_next = x_next - dx;
        y_next = y_next + dy;
        z_next = z_next - $signed({2'b00, ATAN_TURNS[i]});
      end else begin
        x_next = x_next + dx;
        y_next = y_next - dy;
        z_next = z_next + $signed({2'b00, ATAN_TURNS[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= {{2{r_start[31]}}, r_start};
      quad <= q_start;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(CORDIC_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cx = to_q15(x);
  assign cy = to_q15(y);

  always_comb begin
    res.done = done;
    case (quad)
      2'd0: begin
        res.cos_q15 = cx;
        res.sin_q15 = cy;
      end
      2'd1: begin
        res.cos_q15 = -cy;
        res.sin_q15 = cx;
      end
      2'd2: begin
        res.cos_q15 = -cx;
        res.sin_q15 = -cy;
      end
      default: begin
        res.cos_q15 = cy;
        res.sin_q15 = -cx;
      end
    endcase
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a rotation");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("rotation restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

endmodule

// ----- design/saf_engine.sv -----
module saf_engine
  import saf_pkg::*;
#(
  parameter int MAX_STATIONS = 128,
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  item_t       item,
  output logic        pop,
  input  logic [7:0]  num_stations,
  input  logic [27:0] reference_freq_hz,
  output logic        cordic_start,
  output logic [31:0] cordic_angle,
  input  cordic_res_t cordic_res,
  output logic        m_valid,
  output logic [31:0] m_data,
  input  logic        m_ready
);

  localparam int AW = $clog2(MAX_STATIONS);
  localparam int NW = ($clog2(MAX_STATIONS + 1) > 8) ? $clog2(MAX_STATIONS + 1) : 8;
  localparam int SW = 17 + $clog2(MAX_STATIONS);
  localparam int CW = $clog2(SW);

  eng_state_t state;
  eng_state_t state_next;

  logic [71:0]        pos_mem [MAX_STATIONS];
  logic [71:0]        mem_q;
  item_t              cur;
  logic [1:0]         dir_idx;
  logic signed [15:0] trig [8];
  logic signed [15:0] kx, ky, kz, k0x, k0y, k0z;
  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      n_req;
  logic [NW-1:0]      sidx;
  logic [3:0]         step;
  logic signed [23:0] ma;
  logic signed [28:0] mb;
  logic signed [52:0] prod;
  logic signed [63:0] prod64;
  logic signed [41:0] d;
  logic signed [41:0] d0;
  logic signed [63:0] tm;
  logic signed [63:0] tm_round;
  logic signed [33:0] t;
  logic signed [33:0] t0;
  logic signed [63:0] acc;
  logic signed [63:0] acc_round;
  logic signed [SW-1:0] sre;
  logic signed [SW-1:0] sim;
  logic [SW-1:0]      dq_re;
  logic [SW-1:0]      dq_im;
  logic [NW-1:0]      drem_re;
  logic [NW-1:0]      drem_im;
  logic               neg_re;
  logic               neg_im;
  logic [CW-1:0]      dcnt;
  logic [31:0]        dir_angle;
  logic signed [23:0] px, py, pz;
  logic               leave_out;

  function automatic logic [31:0] angle32(input logic [15:0] a);
    logic [31:0] v;
    v = {16'b0, a};
    return {v[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
  endfunction

  function automatic logic signed [15:0] neg_mulq(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return -to_q15({{2{p[31]}}, p});
  endfunction

  function automatic logic [15:0] finish(input logic [SW-1:0] q, input logic neg);
    if (!neg) begin
      return (q > SW'(32767)) ? 16'h7FFF : q[15:0];
    end
    return (q > SW'(32768)) ? 16'h8000 : (~q[15:0] + 16'd1);
  endfunction

  function automatic logic [SW-1:0] magnitude(input logic signed [SW-1:0] s,
                                              input logic [NW-1:0] n);
    logic [SW-1:0] m;
    m = s[SW-1] ? SW'(-s) : SW'(s);
    return m + SW'(n >> 1);
  endfunction

  assign n_req     = (NW'(num_stations) > NW'(MAX_STATIONS)) ? NW'(MAX_STATIONS)
                                                             : NW'(num_stations);
  assign px        = mem_q[23:0];
  assign py        = mem_q[47:24];
  assign pz        = mem_q[71:48];
  assign prod64    = {{11{prod[52]}}, prod};
  assign tm_round  = tm + 64'sd536870912;
  assign acc_round = acc + 64'sd4096;
  assign leave_out = !m_valid || m_ready;

  always_comb begin
    case (dir_idx)
      2'd0:    dir_angle = angle32(cur.dir_azimuth);
      2'd1:    dir_angle = angle32(cur.dir_elevation);
      2'd2:    dir_angle = angle32(cur.ref_azimuth);
      default: dir_angle = angle32(cur.ref_elevation);
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE: begin
        if (item_valid && item.op == OP_EVAL) begin
          state_next = (n_req == '0) ? ENG_OUT : ENG_DIR_START;
        end
      end
      ENG_DIR_START: state_next = ENG_DIR_WAIT;
      ENG_DIR_WAIT: begin
        if (cordic_res.done) begin
          state_next = (dir_idx == 2'd3) ? ENG_KVEC : ENG_DIR_START;
        end
      end
      ENG_KVEC: state_next = ENG_READ;
      ENG_READ: state_next = ENG_MAC;
      ENG_MAC: begin
        if (step == MAC_LAST) begin
          state_next = ENG_ROT_WAIT;
        end
      end
      ENG_ROT_WAIT: begin
        if (cordic_res.done) begin
          state_next = (sidx == n_eff - NW'(1)) ? ENG_DIV_SETUP : ENG_READ;
        end
      end
      ENG_DIV_SETUP: state_next = ENG_DIV;
      ENG_DIV: begin
        if (dcnt == CW'(SW - 1)) begin
          state_next = ENG_OUT;
        end
      end
      ENG_OUT: begin
        if (leave_out) begin
          state_next = ENG_IDLE;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == ENG_IDLE) && item_valid;
    cordic_start = (state == ENG_DIR_START) || (state == ENG_MAC && step == MAC_LAST);
    cordic_angle = (state == ENG_MAC) ? acc_round[44:13] : dir_angle;
  end

  always_comb begin
    case (step)
      4'd0: begin
        ma = px;
        mb = 29'(kx);
      end
      4'd1: begin
        ma = py;
        mb = 29'(ky);
      end
      4'd2: begin
        ma = pz;
        mb = 29'(kz);
      end
      4'd3: begin
        ma = px;
        mb = 29'(k0x);
      end
      4'd4: begin
        ma = py;
        mb = 29'(k0y);
      end
      4'd5: begin
        ma = pz;
        mb = 29'(k0z);
      end
      4'd6: begin
        ma = {4'b0, d[19:0]};
        mb = DELAY_MUL;
      end
      4'd7: begin
        ma = {{2{d[41]}}, d[41:20]};
        mb = DELAY_MUL;
      end
      4'd8: begin
        ma = {4'b0, d0[19:0]};
        mb = DELAY_MUL;
      end
      4'd9: begin
        ma = {{2{d0[41]}}, d0[41:20]};
        mb = DELAY_MUL;
      end
      4'd10: begin
        ma = {7'b0, t[16:0]};
        mb = {1'b0, cur.frequency_hz};
      end
      4'd11: begin
        ma = {{7{t[33]}}, t[33:17]};
        mb = {1'b0, cur.frequency_hz};
      end
      4'd12: begin
        ma = {7'b0, t0[16:0]};
        mb = {1'b0, reference_freq_hz};
      end
      4'd13: begin
        ma = {{7{t0[33]}}, t0[33:17]};
        mb = {1'b0, reference_freq_hz};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && item.op == OP_LOAD && 32'(item.station_index) < MAX_STATIONS) begin
      pos_mem[AW'(item.station_index)] <= {item.pos_z, item.pos_y, item.pos_x};
    end
    if (state == ENG_READ) begin
      mem_q <= pos_mem[sidx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ENG_IDLE && pop) begin
      cur     <= item;
      n_eff   <= n_req;
      dir_idx <= '0;
      sidx    <= '0;
      sre     <= '0;
      sim     <= '0;
      dq_re   <= '0;
      dq_im   <= '0;
      neg_re  <= 1'b0;
      neg_im  <= 1'b0;
    end
    if (state == ENG_DIR_WAIT && cordic_res.done) begin
      trig[{dir_idx, 1'b0}] <= cordic_res.cos_q15;
      trig[{dir_idx, 1'b1}] <= cordic_res.sin_q15;
      dir_idx <= dir_idx + 2'd1;
    end
    if (state == ENG_KVEC) begin
      kx  <= neg_mulq(trig[2], trig[0]);
      ky  <= neg_mulq(trig[2], trig[1]);
      kz  <= -trig[3];
      k0x <= neg_mulq(trig[6], trig[4]);
      k0y <= neg_mulq(trig[6], trig[5]);
      k0z <= -trig[7];
    end
    if (state == ENG_READ) begin
      step <= '0;
    end
    if (state == ENG_MAC) begin
      step <= step + 4'd1;
      prod <= ma * mb;
      case (step)
        4'd1: d <= prod[41:0];
        4'd2, 4'd3: d <= d + $signed(prod[41:0]);
        4'd4: d0 <= prod[41:0];
        4'd5, 4'd6: d0 <= d0 + $signed(prod[41:0]);
        4'd7: tm <= prod64;
        4'd8: tm <= tm + (prod64 <<< 20);
        4'd9: begin
          t  <= tm_round[63:30];
          tm <= prod64;
        end
        4'd10: tm <= tm + (prod64 <<< 20);
        4'd11: begin
          t0  <= tm_round[63:30];
          acc <= -prod64;
        end
        4'd12: acc <= acc - (prod64 <<< 17);
        4'd13: acc <= acc + prod64;
        4'd14: acc <= acc + (prod64 <<< 17);
        default: acc <= acc;
      endcase
    end
    if (state == ENG_ROT_WAIT && cordic_res.done) begin
      sre  <= sre + SW'(cordic_res.cos_q15);
      sim  <= sim + SW'(cordic_res.sin_q15);
      sidx <= sidx + NW'(1);
    end
    if (state == ENG_DIV_SETUP) begin
      dq_re   <= magnitude(sre, n_eff);
      dq_im   <= magnitude(sim, n_eff);
      neg_re  <= sre[SW-1];
      neg_im  <= sim[SW-1];
      drem_re <= '0;
      drem_im <= '0;
      dcnt    <= '0;
    end
    if (state == ENG_DIV) begin
      dcnt <= dcnt + CW'(1);
      if ({drem_re, dq_re[SW-1]} >= {1'b0, n_eff}) begin
        drem_re <= NW'({drem_re, dq_re[SW-1]} - {1'b0, n_eff});
        dq_re   <= {dq_re[SW-2:0], 1'b1};
      end else begin
        drem_re <= {drem_re[NW-2:0], dq_re[SW-1]};
        dq_re   <= {dq_re[SW-2:0], 1'b0};
      end
      if ({drem_im, dq_im[SW-1]} >= {1'b0, n_eff}) begin
        drem_im <= NW'({drem_im, dq_im[SW-1]} - {1'b0, n_eff});
        dq_im   <= {dq_im[SW-2:0], 1'b1};
      end else begin
        drem_im <= {drem_im[NW-2:0], dq_im[SW-1]};
        dq_im   <= {dq_im[SW-2:0], 1'b0};
      end
    end
    if (state == ENG_OUT && leave_out) begin
      m_data <= {finish(dq_im, neg_im), finish(dq_re, neg_re)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ENG_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ENG_OUT && leave_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    cordic_start |=> !cordic_res.done) else $error("rotation result came too early");
  a_station_bound: assert property (@(posedge clk) disable iff (rst)
    state == ENG_MAC |-> sidx < n_eff) else $error("station walk past the count");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ENG_DIV |-> n_eff != '0) else $error("average with zero stations");
  a_mac_to_rot: assert property (@(posedge clk) disable iff (rst)
    (state == ENG_MAC && step == MAC_LAST) |=> state == ENG_ROT_WAIT)
    else $error("phase step sequence broken");

endmodule

// ----- design/station_array_factor_top.sv -----
// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid/s_axis_tready    tuser opcode, tdata station and angles
// m_axis    out        m_axis_tvalid/m_axis_tready    tdata factor_real, factor_imag
// cfg       in         cfg_valid/cfg_ready            cfg_index register, cfg_data value
//
// A load word writes one table entry; an evaluate word takes longer as the station count n
// grows, set by the per-station multiply sequence on the one shared multiplier and the
// iterative rotation unit. Reset is synchronous and resets control and configuration only;
// the position table holds no valid data until loaded. Input words queue two deep while the
// back end works, and one finished result waits in the output register as the next starts.
module station_array_factor_top
  import saf_pkg::*;
#(
  parameter int MAX_STATIONS = 128,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // station_index, pos_x, pos_y, pos_z, dir_azimuth, dir_elevation,
  // ref_azimuth, ref_elevation, frequency_hz
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // factor_real, factor_imag
  output logic [31:0]        m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic        num_stations_w;
  logic [7:0]  num_stations;
  logic [27:0] reference_freq_hz;
  logic        item_valid;
  item_t       item;
  logic        pop;
  logic        cordic_start;
  logic [31:0] cordic_angle;
  cordic_res_t cordic_res;

  assign cfg_ready      = 1'b1;
  assign num_stations_w = cfg_valid && cfg_index == CFG_NUM_STATIONS;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stations      <= 8'd1;
      reference_freq_hz <= '0;
    end else begin
      if (num_stations_w) begin
        num_stations <= cfg_data[7:0];
      end
      if (cfg_valid && cfg_index == CFG_REF_FREQ) begin
        reference_freq_hz <= cfg_data[27:0];
      end
    end
  end

  saf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop           (pop),
    .item_valid    (item_valid),
    .item          (item)
  );

  saf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (cordic_angle),
    .res   (cordic_res)
  );

  saf_engine #(
    .MAX_STATIONS (MAX_STATIONS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item              (item),
    .pop               (pop),
    .num_stations      (num_stations),
    .reference_freq_hz (reference_freq_hz),
    .cordic_start      (cordic_start),
    .cordic_angle      (cordic_angle),
    .cordic_res        (cordic_res),
    .m_valid           (m_axis_tvalid),
    .m_data            (m_axis_tdata),
    .m_ready           (m_axis_tready)
  );

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import saf_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES = 4000;
  localparam logic [7:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [7:0] CFG_UNUSED_HI = 8'd255;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [31:0] cfg_data;

  station_array_factor_top u_top (.*);

  logic signed [23:0] stn_pos [TABLE_DEPTH][3];
  logic [7:0] stn_count;
  logic [27:0] ref_freq;
  logic [31:0] pending_factors [$];
  int errors;
  int idle_cycles;
  bit no_gaps;
  bit hold_output;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r[15:0];
  endfunction

  task automatic rotate(input logic [31:0] a, output logic signed [15:0] c,
                        output logic signed [15:0] s);
    logic [1:0] q;
    logic [31:0] r;
    longint x, y, z, dx, dy;
    logic signed [15:0] cx, cy;
    q = 2'((a + 32'h20000000) >> 30);
    r = a - (32'(q) << 30);
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    cx = round_q15(x);
    cy = round_q15(y);
    case (q)
      2'd0: begin c = cx; s = cy; end
      2'd1: begin c = -cy; s = cx; end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endtask

  task automatic look_vector(input logic [15:0] az, input logic [15:0] el,
                             output longint k [3]);
    logic signed [15:0] caz, saz, cel, sel;
    rotate({az, 16'h0}, caz, saz);
    rotate({el, 16'h0}, cel, sel);
    k[0] = -longint'(round_q15(longint'(cel) * longint'(caz)));
    k[1] = -longint'(round_q15(longint'(cel) * longint'(saz)));
    k[2] = -longint'(sel);
  endtask

  function automatic longint path_delay(input longint k [3], input int idx);
    longint d;
    d = k[0] * longint'(stn_pos[idx][0]) + k[1] * longint'(stn_pos[idx][1])
      + k[2] * longint'(stn_pos[idx][2]);
    return (d * 3845732 + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic logic [15:0] mean_q15(input int sum, input int n);
    int mag, r;
    mag = sum < 0 ? -sum : sum;
    r = (mag + n / 2) / n;
    if (sum < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_factor(input item_t it);
    longint k [3], k0 [3];
    longint t, t0, acc;
    logic [31:0] phase;
    logic signed [15:0] c, s;
    int n, sre, sim;
    n = stn_count > TABLE_DEPTH ? TABLE_DEPTH : stn_count;
    if (n == 0) begin
      pending_factors.push_back(32'h0);
      return;
    end
    look_vector(it.dir_azimuth, it.dir_elevation, k);
    look_vector(it.ref_azimuth, it.ref_elevation, k0);
    sre = 0;
    sim = 0;
    for (int i = 0; i < n; i++) begin
      t = path_delay(k, i);
      t0 = path_delay(k0, i);
      acc = longint'(ref_freq) * t0 - longint'(it.frequency_hz) * t;
      phase = 32'((acc + 4096) >>> 13);
      rotate(phase, c, s);
      sre += c;
      sim += s;
    end
    pending_factors.push_back({mean_q15(sim, n), mean_q15(sre, n)});
  endtask

  function automatic int gap_draw();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  // Called at a falling edge; returns at a falling edge with the word taken.
  task automatic send_word(input item_t it);
    int gap;
    gap = gap_draw();
    s_axis_tvalid = 1'b0;
    repeat (gap) @(negedge clk);
    s_axis_tuser = it.op;
    s_axis_tdata = {5'b0, it.frequency_hz, it.ref_elevation, it.ref_azimuth,
                    it.dir_elevation, it.dir_azimuth, it.pos_z, it.pos_y, it.pos_x,
                    it.station_index};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (it.op == OP_LOAD) begin
      stn_pos[it.station_index][0] = it.pos_x;
      stn_pos[it.station_index][1] = it.pos_y;
      stn_pos[it.station_index][2] = it.pos_z;
    end else begin
      predict_factor(it);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic item_t random_item(input op_t op);
    item_t it;
    it.op = op;
    it.station_index = 7'($urandom);
    it.pos_x = 24'($urandom);
    it.pos_y = 24'($urandom);
    it.pos_z = 24'($urandom);
    it.dir_azimuth = 16'($urandom);
    it.dir_elevation = 16'($urandom);
    it.ref_azimuth = 16'($urandom);
    it.ref_elevation = 16'($urandom);
    it.frequency_hz = 28'($urandom);
    return it;
  endfunction

  task automatic eval_at(input logic [15:0] az, input logic [15:0] el,
                         input logic [15:0] az0, input logic [15:0] el0,
                         input logic [27:0] f);
    item_t it;
    it = random_item(OP_EVAL);
    it.dir_azimuth = az;
    it.dir_elevation = el;
    it.ref_azimuth = az0;
    it.ref_elevation = el0;
    it.frequency_hz = f;
    send_word(it);
  endtask

  task automatic load_at(input int idx, input logic signed [23:0] x,
                         input logic signed [23:0] y, input logic signed [23:0] z);
    item_t it;
    it = random_item(OP_LOAD);
    it.station_index = 7'(idx);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    send_word(it);
  endtask

  task automatic wait_drained();
    while (pending_factors.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    wait_drained();
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NUM_STATIONS) stn_count = value[7:0];
    else if (idx == CFG_REF_FREQ) ref_freq = value[27:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_fill_table();
    load_at(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    load_at(1, -24'sh800000, -24'sh800000, -24'sh800000);
    load_at(2, 24'sh0, 24'sh0, 24'sh0);
    for (int i = 3; i < TABLE_DEPTH; i++) begin
      load_at(i, 24'($urandom), 24'($urandom), 24'($urandom));
    end
  endtask

  task automatic test_directed();
    eval_at(16'h0000, 16'h0000, 16'h0000, 16'h0000, 28'h0);
    eval_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 28'hFFFFFFF);
    write_reg(CFG_NUM_STATIONS, 32'd3);
    write_reg(CFG_REF_FREQ, 32'h0FFFFFFF);
    eval_at(16'h4000, 16'h2000, 16'hC000, 16'hE000, 28'hFFFFFFF);
    eval_at(16'h8000, 16'h4000, 16'h0000, 16'h4000, 28'd150000000);
    eval_at(16'h2000, 16'hC000, 16'h8000, 16'h0000, 28'd1);
    write_reg(CFG_NUM_STATIONS, 32'd0);
    eval_at(16'h1234, 16'h0800, 16'h1000, 16'h0800, 28'd120000000);
    write_reg(CFG_NUM_STATIONS, 32'd255);
    eval_at(16'h3000, 16'h1000, 16'h3100, 16'h1100, 28'd60000000);
    write_reg(CFG_NUM_STATIONS, 32'd128);
    write_reg(CFG_REF_FREQ, 32'h0);
    eval_at(16'h0000, 16'h4000, 16'h0000, 16'h4000, 28'hFFFFFFF);
    write_reg(CFG_UNUSED_LO, 32'hFFFFFFFF);
    write_reg(CFG_UNUSED_HI, 32'hFFFFFFFF);
    write_reg(CFG_NUM_STATIONS, 32'd1);
    eval_at(16'hA000, 16'h6000, 16'h5000, 16'h7000, 28'd30000000);
    load_at(0, 24'sh123456, -24'sh000001, 24'sh000001);
    eval_at(16'hA000, 16'h6000, 16'h5000, 16'h7000, 28'd30000000);
  endtask

  task automatic test_random_mix();
    item_t it;
    for (int blk = 0; blk < 15; blk++) begin
      write_reg(CFG_NUM_STATIONS, $urandom_range(0, 11) == 0 ?
                $urandom_range(9, 48) : $urandom_range(1, 8));
      write_reg(CFG_REF_FREQ, blk == 3 ? 32'h0FFFFFFF : 32'($urandom));
      no_gaps = (blk % 4 == 1);
      for (int i = 0; i < 100; i++) begin
        it = random_item($urandom_range(0, 1) ? OP_EVAL : OP_LOAD);
        send_word(it);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_stall();
    write_reg(CFG_NUM_STATIONS, 32'd2);
    hold_output = 1'b1;
    for (int i = 0; i < 6; i++) send_word(random_item(OP_EVAL));
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stn_count = 8'd1;
    ref_freq = '0;
    errors = 0;
    no_gaps = 1'b0;
    hold_output = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_fill_table();
    test_directed();
    test_random_mix();
    test_output_stall();
    wait_drained();
    if (errors == 0) begin
      $display("station_array_factor_top: match");
    end else begin
      $display("station_array_factor_top: mismatch");
    end
    $finish;
  end

  initial begin
    logic [31:0] want;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      m_axis_tready = 1'b0;
      repeat (gap_draw()) @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_factors.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_factors.pop_front();
        if (m_axis_tdata[15:0] !== want[15:0]) begin
          $display("%0t: factor_real expected %0d actual %0d", $time,
                   $signed(want[15:0]), $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== want[31:16]) begin
          $display("%0t: factor_imag expected %0d actual %0d", $time,
                   $signed(want[31:16]), $signed(m_axis_tdata[31:16]));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("station_array_factor_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
